[hdl/kdlp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_pkg: shared types and constants for the key debounce block
// Key state encodings, event codes, widths and the item structs that pass
// from the front stage through the queue to the key engine.
// ----------------------------------------------------------------------------
package kdlp_pkg;

   // key table size (index field is 3 bits wide, so at most 8 keys)
   localparam int NUM_KEYS  = 8;
   localparam int KEY_IDX_W = 3;
   localparam int KEY_AW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int CNT_W     = 8;
   localparam int EVT_W     = 2;
   localparam int STC_W     = 3;
   localparam int TDATA_W   = 8;

   // per-key debounce state, one-hot
   typedef enum logic [4:0] {
      KS_IDLE    = 5'b00001,
      KS_DOWNC   = 5'b00010,
      KS_PRESSED = 5'b00100,
      KS_LONG    = 5'b01000,
      KS_UPC     = 5'b10000
   } kdlp_state_type;

   // reported state codes
   localparam logic [STC_W-1:0] STC_IDLE    = 3'd0;
   localparam logic [STC_W-1:0] STC_DOWNC   = 3'd1;
   localparam logic [STC_W-1:0] STC_PRESSED = 3'd2;
   localparam logic [STC_W-1:0] STC_LONG    = 3'd3;
   localparam logic [STC_W-1:0] STC_UPC     = 3'd4;

   // event codes
   typedef enum logic [EVT_W-1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_LONG    = 2'd2,
      EV_RELEASE = 2'd3
   } kdlp_event_type;

   // classified poll sample
   typedef struct packed {
      logic                 in_range;
      logic [KEY_IDX_W-1:0] key_index;
      logic                 key_level;
   } kdlp_item_type;

   // result of one poll sample
   typedef struct packed {
      logic [STC_W-1:0]     key_state_now;
      kdlp_event_type       key_event;
      logic [KEY_IDX_W-1:0] key_id;
   } kdlp_result_type;

   // one-hot state to reported code
   function automatic logic [STC_W-1:0] state_code(kdlp_state_type st);
      logic [STC_W-1:0] code;
      case (st)
         KS_IDLE:    code = STC_IDLE;
         KS_DOWNC:   code = STC_DOWNC;
         KS_PRESSED: code = STC_PRESSED;
         KS_LONG:    code = STC_LONG;
         KS_UPC:     code = STC_UPC;
         default:    code = STC_IDLE;
      endcase
      return code;
   endfunction

   // counter increment, sticks at all ones
   function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
   endfunction

endpackage

[hdl/key_debounce_long_press_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_long_press_top: per-key debounce with long-press detection
// Poll samples enter an intake stage, pass a two-entry queue and are
// applied to the per-key state table; each sample yields one result.
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  req_tdata  [2:0] key_index, [3] key_level
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata  [2:0] key_id, [4:3] key_event,
//                                                 [7:5] key_state_now
// csr      in   csr_wr_en              csr_wr_data[7:0] debounce_ticks
//
// One sample per cycle sustained while rsp is not stalled; each sample passes the
// intake register, the queue and the key engine output register before its result
// is presented. The key table read-modify-write is a combinational read with a
// registered write, so samples for the same key may follow back to back.
// Synchronous reset clears the key table and sets debounce_ticks to 3. A stall
// on rsp fills the output register, then the queue, then the intake stage
// before req_tready drops.
// ----------------------------------------------------------------------------
module key_debounce_long_press_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [kdlp_pkg::TDATA_W-1:0]  req_tdata,   // key_index, key_level
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [kdlp_pkg::TDATA_W-1:0]  rsp_tdata,   // key_id, key_event, key_state_now
   input  logic                          csr_wr_en,
   input  logic [kdlp_pkg::CNT_W-1:0]    csr_wr_data
);
   import kdlp_pkg::*;

   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd3;

   logic [CNT_W-1:0] debounce_ff;
   logic             push_valid, push_ready;
   kdlp_item_type    push_item;
   logic             pop_valid, pop_ready;
   kdlp_item_type    pop_item;
   kdlp_result_type  rsp_result;

   // debounce threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_wr_en) begin
         debounce_ff <= csr_wr_data;
      end
   end

   kdlp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   kdlp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   kdlp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .debounce_ticks (debounce_ff),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_item       (pop_item),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_result     (rsp_result)
   );

   // result struct is declared high field first, so its packed bits match tdata
   assign rsp_tdata = TDATA_W'(rsp_result);

endmodule

[hdl/kdlp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_front: sample intake
// Takes poll samples from the request stream, checks the key index against
// the table size and holds the classified item until the queue takes it.
// ----------------------------------------------------------------------------
module kdlp_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [kdlp_pkg::TDATA_W-1:0]     req_tdata,
   output logic                             push_valid,
   input  logic                             push_ready,
   output kdlp_pkg::kdlp_item_type          push_item
);
   import kdlp_pkg::*;

   logic          stg_valid_ff, stg_valid_in;
   kdlp_item_type stg_item_ff,  stg_item_in;
   logic          req_xfer;

   // stage is free when empty or draining this cycle
   assign req_tready = !stg_valid_ff || push_ready;
   assign req_xfer   = req_tvalid && req_tready;

   // classify the incoming sample
   always_comb begin
      stg_item_in           = stg_item_ff;
      stg_valid_in          = stg_valid_ff;
      if (push_ready) begin
         stg_valid_in = 1'b0;
      end
      if (req_xfer) begin
         stg_valid_in          = 1'b1;
         stg_item_in.key_index = req_tdata[KEY_IDX_W-1:0];
         stg_item_in.key_level = req_tdata[KEY_IDX_W];
         stg_item_in.in_range  =
            ({1'b0, req_tdata[KEY_IDX_W-1:0]} < (KEY_IDX_W+1)'(NUM_KEYS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
      stg_item_ff <= stg_item_in;
   end

   assign push_valid = stg_valid_ff;
   assign push_item  = stg_item_ff;

endmodule

[hdl/kdlp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_queue: two-entry item queue
// Decouples the intake stage from the key engine so either side can stall.
// ----------------------------------------------------------------------------
module kdlp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  kdlp_pkg::kdlp_item_type    push_item,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output kdlp_pkg::kdlp_item_type    pop_item
);
   import kdlp_pkg::*;

   localparam int DEPTH = 2;

   kdlp_item_type slot_ff [DEPTH];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff,  count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != 2'(DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   // occupancy never exceeds depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("queue overflow");

   // occupancy tracks the transfers on both sides
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_ff) + 2'($past(do_push))
                                    - 2'($past(do_pop)))
      else $error("queue count mismatch");

   // pointers differ exactly when queue is neither empty nor full
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff != rd_ptr_ff) == (count_ff == 2'd1))
      else $error("queue pointers inconsistent");
`endif

endmodule

[hdl/kdlp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_back: key engine
// Per-key read-modify-write of the debounce state and tick counters, one
// sample per cycle unless rsp stalls; the result is held in an output register.
// ----------------------------------------------------------------------------
module kdlp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [kdlp_pkg::CNT_W-1:0]    debounce_ticks,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  kdlp_pkg::kdlp_item_type       pop_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output kdlp_pkg::kdlp_result_type     rsp_result
);
   import kdlp_pkg::*;

   kdlp_state_type  key_st_ff [NUM_KEYS];
   logic [CNT_W-1:0] down_ff  [NUM_KEYS];
   logic [CNT_W-1:0] up_ff    [NUM_KEYS];

   logic            rsp_valid_ff, rsp_valid_in;
   kdlp_result_type rsp_ff,       rsp_in;

   logic             do_pop;
   logic [KEY_AW-1:0] idx;
   kdlp_state_type   st_cur, st_nxt;
   logic [CNT_W-1:0] dn_cur, dn_nxt, dn_inc;
   logic [CNT_W-1:0] up_cur, up_nxt, up_inc;
   kdlp_event_type   ev;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign do_pop    = pop_valid && pop_ready;
   assign idx       = pop_item.key_index[KEY_AW-1:0];
   assign st_cur    = key_st_ff[idx];
   assign dn_cur    = down_ff[idx];
   assign up_cur    = up_ff[idx];
   assign dn_inc    = sat_inc(dn_cur);
   assign up_inc    = sat_inc(up_cur);

   // debounce transition for the selected key
   always_comb begin
      st_nxt = st_cur;
      dn_nxt = dn_cur;
      up_nxt = up_cur;
      ev     = EV_NONE;
      case (st_cur)
         KS_IDLE: begin
            if (pop_item.key_level) begin
               st_nxt = KS_DOWNC;
            end
         end
         KS_DOWNC, KS_PRESSED: begin
            if (pop_item.key_level) begin
               dn_nxt = dn_inc;
               if (dn_inc >= debounce_ticks) begin
                  dn_nxt = '0;
                  if (st_cur == KS_DOWNC) begin
                     st_nxt = KS_PRESSED;
                     ev     = EV_PRESS;
                  end else begin
                     st_nxt = KS_LONG;
                     ev     = EV_LONG;
                  end
               end
            end else begin
               st_nxt = KS_UPC;
               dn_nxt = '0;
               up_nxt = '0;
            end
         end
         KS_LONG: begin
            if (pop_item.key_level) begin
               dn_nxt = dn_inc;
            end else begin
               st_nxt = KS_UPC;
               dn_nxt = '0;
               up_nxt = '0;
            end
         end
         KS_UPC: begin
            if (pop_item.key_level) begin
               st_nxt = KS_DOWNC;
               dn_nxt = '0;
               up_nxt = '0;
            end else begin
               up_nxt = up_inc;
               if (up_inc >= debounce_ticks) begin
                  up_nxt = '0;
                  st_nxt = KS_IDLE;
                  ev     = EV_RELEASE;
               end
            end
         end
         default: begin
            st_nxt = KS_IDLE;
            dn_nxt = '0;
            up_nxt = '0;
         end
      endcase
   end

   // output register: load on pop, clear when taken
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (do_pop) begin
         rsp_valid_in      = 1'b1;
         rsp_in.key_id     = pop_item.key_index;
         if (pop_item.in_range) begin
            rsp_in.key_event     = ev;
            rsp_in.key_state_now = state_code(st_nxt);
         end else begin
            rsp_in.key_event     = EV_NONE;
            rsp_in.key_state_now = STC_IDLE;
         end
      end
   end

   // key table and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            key_st_ff[k] <= KS_IDLE;
            down_ff[k]   <= '0;
            up_ff[k]     <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (do_pop && pop_item.in_range) begin
            key_st_ff[idx] <= st_nxt;
            down_ff[idx]   <= dn_nxt;
            up_ff[idx]     <= up_nxt;
         end
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

`ifndef SYNTHESIS
   // a press event always leaves the key pressed
   a_press_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.key_event == EV_PRESS |-> rsp_ff.key_state_now == STC_PRESSED)
      else $error("press event with wrong state");

   // a long-press event always leaves the key long pressed
   a_long_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.key_event == EV_LONG |-> rsp_ff.key_state_now == STC_LONG)
      else $error("long-press event with wrong state");

   // a release event always returns the key to idle
   a_release_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.key_event == EV_RELEASE |-> rsp_ff.key_state_now == STC_IDLE)
      else $error("release event with wrong state");

   // a result waiting on a stall is not overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result overwritten while stalled");
`endif

endmodule
